### sv/spq_pkg.sv
// Shared codes and the result record of the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Operation codes carried by an input beat.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  // Status codes carried by a result beat.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Widths of the result fields.
  localparam int unsigned PosW   = 5;
  localparam int unsigned ValueW = 32;

  // One result beat as the sequencer hands it to the top level.
  typedef struct packed {
    logic [1:0]        status;
    logic [PosW-1:0]   position;
    logic [ValueW-1:0] head_value;
    logic              head_valid;
    logic [PosW-1:0]   entry_count;
  } res_t;

endpackage

### sv/spq_mem.sv
// Entry store: one write port and one registered read port.
`timescale 1ns / 1ps

module spq_mem #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned AddrW = $clog2(CAPACITY)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AddrW-1:0]             waddr_i,
  input  logic [spq_pkg::ValueW-1:0]   wdata_i,
  input  logic                         re_i,
  input  logic [AddrW-1:0]             raddr_i,
  output logic [spq_pkg::ValueW-1:0]   rdata_o
);

  logic [spq_pkg::ValueW-1:0] mem [CAPACITY];
  logic [spq_pkg::ValueW-1:0] rdata_q;

  // Write and read; read data is registered and appears in the cycle after the request.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/spq_ctrl.sv
// Sequencer: walks the entry store, shifts entries and builds each result.
`timescale 1ns / 1ps

module spq_ctrl #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned AddrW = $clog2(CAPACITY),
  localparam int unsigned CntW  = $clog2(CAPACITY + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [1:0]                   op_i,
  input  logic [spq_pkg::ValueW-1:0]   item_value_i,
  output logic                         busy_o,
  output logic                         done_o,
  output spq_pkg::res_t                res_o,
  output logic                         mem_we_o,
  output logic [AddrW-1:0]             mem_waddr_o,
  output logic [spq_pkg::ValueW-1:0]   mem_wdata_o,
  output logic                         mem_re_o,
  output logic [AddrW-1:0]             mem_raddr_o,
  input  logic [spq_pkg::ValueW-1:0]   mem_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_PLACE = 3'b100
  } state_e;

  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  state_e                     state_q, state_d;
  logic [1:0]                 op_q, op_d;
  logic [spq_pkg::ValueW-1:0] val_q, val_d;
  logic [spq_pkg::ValueW-1:0] head_q, head_d;
  logic [AddrW-1:0]           idx_q, idx_d;
  logic [AddrW-1:0]           pos_q, pos_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [1:0]                 status_q, status_d;
  logic                       found_q, found_d;
  logic                       done_q, done_d;

  logic [AddrW-1:0]           last_idx;
  logic                       at_last;
  logic                       match;
  logic                       above;
  logic [31:0]                pos_ext;
  logic [31:0]                count_ext;

  assign last_idx = AddrW'(count_q - CntW'(1));
  assign at_last  = (CntW'(idx_q) + CntW'(1)) == count_q;
  assign match    = mem_rdata_i == val_q;
  assign above    = $signed(mem_rdata_i) > $signed(val_q);

  // Next-state logic. Insert walks down from the tail moving larger entries
  // up by one; remove and find walk up from the head, and remove moves each
  // entry past the match down by one. Writes always trail the read pointer,
  // so a read never hits an entry written in the same or the previous cycle.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    head_d      = head_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    count_d     = count_q;
    status_d    = status_q;
    found_d     = found_q;
    done_d      = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = val_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = op_i;
          val_d   = item_value_i;
          found_d = 1'b0;
          pos_d   = '0;
          case (op_i) inside
            spq_pkg::OP_INSERT: begin
              if (count_q == CapCnt) begin
                status_d = spq_pkg::ST_FULL;
                done_d   = 1'b1;
              end else if (count_q == '0) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = '0;
                mem_wdata_o = item_value_i;
                count_d     = count_q + CntW'(1);
                status_d    = spq_pkg::ST_OK;
                done_d      = 1'b1;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = last_idx;
                idx_d       = last_idx;
                state_d     = S_SCAN;
              end
            end
            spq_pkg::OP_REMOVE, spq_pkg::OP_FIND: begin
              if (count_q == '0) begin
                status_d = spq_pkg::ST_MISSING;
                done_d   = 1'b1;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                idx_d       = '0;
                state_d     = S_SCAN;
              end
            end
            default: begin
              status_d = spq_pkg::ST_MISSING;
              done_d   = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        case (op_q)
          spq_pkg::OP_INSERT: begin
            mem_we_o    = 1'b1;
            mem_waddr_o = idx_q + AddrW'(1);
            if (above) begin
              mem_wdata_o = mem_rdata_i;
              if (idx_q == '0) begin
                state_d = S_PLACE;
              end else begin
                idx_d       = idx_q - AddrW'(1);
                mem_re_o    = 1'b1;
                mem_raddr_o = idx_q - AddrW'(1);
              end
            end else begin
              mem_wdata_o = val_q;
              pos_d       = idx_q + AddrW'(1);
              count_d     = count_q + CntW'(1);
              status_d    = spq_pkg::ST_OK;
              done_d      = 1'b1;
              state_d     = S_IDLE;
            end
          end
          spq_pkg::OP_REMOVE: begin
            if (found_q) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = idx_q - AddrW'(1);
              mem_wdata_o = mem_rdata_i;
            end else if (match) begin
              found_d = 1'b1;
              pos_d   = idx_q;
            end
            if (at_last) begin
              if (found_q || match) begin
                count_d  = count_q - CntW'(1);
                status_d = spq_pkg::ST_OK;
              end else begin
                status_d = spq_pkg::ST_MISSING;
              end
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              idx_d       = idx_q + AddrW'(1);
              mem_re_o    = 1'b1;
              mem_raddr_o = idx_q + AddrW'(1);
            end
          end
          default: begin
            // Find stops at the first match or after the tail entry.
            if (match) begin
              pos_d    = idx_q;
              status_d = spq_pkg::ST_OK;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else if (at_last) begin
              status_d = spq_pkg::ST_MISSING;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              idx_d       = idx_q + AddrW'(1);
              mem_re_o    = 1'b1;
              mem_raddr_o = idx_q + AddrW'(1);
            end
          end
        endcase
      end

      S_PLACE: begin
        // Every entry was larger, so the new value becomes the head.
        mem_we_o    = 1'b1;
        mem_waddr_o = '0;
        mem_wdata_o = val_q;
        pos_d       = '0;
        count_d     = count_q + CntW'(1);
        status_d    = spq_pkg::ST_OK;
        done_d      = 1'b1;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The head register mirrors every write to the first entry.
    if (mem_we_o && (mem_waddr_o == '0)) begin
      head_d = mem_wdata_o;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    head_q   <= head_d;
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  // Result beat; counts are reported modulo the field width.
  assign pos_ext   = 32'(pos_q);
  assign count_ext = 32'(count_q);

  assign busy_o             = state_q != S_IDLE;
  assign done_o             = done_q;
  assign res_o.status       = status_q;
  assign res_o.position     = pos_ext[spq_pkg::PosW-1:0];
  assign res_o.head_valid   = count_q != '0;
  assign res_o.head_value   = (count_q != '0) ? head_q : '0;
  assign res_o.entry_count  = count_ext[spq_pkg::PosW-1:0];

endmodule

### sv/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: sequencer and entry store.
//
//   Channel   Direction  Handshake                Fields
//   command   in         start_i, busy_o          op_i, item_value_i
//   result    out        done_o (one-cycle beat)  status_o, position_o,
//                                                 head_value_o, head_valid_o,
//                                                 entry_count_o
//
// A command beat is taken when start_i is high and busy_o is low. With n
// entries stored, insert walks down from the tail to its position (with a last
// step writing the head when the value becomes the head), remove walks all n
// entries and find walks up from the head to the match (all n entries when the
// value is absent), one entry per cycle through the single read port of the
// store; full-store, empty-store and unknown commands finish at once. The
// result beat follows on the next cycle, and a new command may be taken in
// that same cycle. Reset empties the queue; the receiver cannot stall results.
`timescale 1ns / 1ps

module sorted_priority_queue_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          op_i,
  input  logic signed [31:0]  item_value_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [4:0]          position_o,
  output logic signed [31:0]  head_value_o,
  output logic                head_valid_o,
  output logic [4:0]          entry_count_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);

  spq_pkg::res_t               res;
  logic                        mem_we;
  logic [AddrW-1:0]            mem_waddr;
  logic [spq_pkg::ValueW-1:0]  mem_wdata;
  logic                        mem_re;
  logic [AddrW-1:0]            mem_raddr;
  logic [spq_pkg::ValueW-1:0]  mem_rdata;

  // Sequencer.
  spq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .op_i         (op_i),
    .item_value_i (item_value_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // Entry store.
  spq_mem #(
    .CAPACITY (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result fields.
  assign status_o      = res.status;
  assign position_o    = res.position;
  assign head_value_o  = res.head_value;
  assign head_valid_o  = res.head_valid;
  assign entry_count_o = res.entry_count;

endmodule

### sv/spq_checker.sv
// Port-level checks of the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps

module spq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic [1:0]         status_o,
  input logic [4:0]         position_o,
  input logic signed [31:0] head_value_o,
  input logic               head_valid_o,
  input logic [4:0]         entry_count_o
);

  // The queue only turns busy after taking a command beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without an accepted command beat");

  // A result beat is shown only once the work is finished.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result beat while still busy");

  // A result beat follows either work in progress or an accepted command.
  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy_o) || $past(start_i)))
    else $error("result beat without a command");

  // Failed operations report position zero, and an empty queue a zero head.
  a_fail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != spq_pkg::ST_OK) |-> (position_o == 5'd0))
    else $error("failed operation reported a nonzero position");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !head_valid_o |-> (head_value_o == 32'sd0) && (entry_count_o == 5'd0))
    else $error("empty queue reported a head value or entries");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);

### tb/sv/sorted_priority_queue_checker.sv
// Checker for the sorted priority queue: predicts each result beat and compares it.
`timescale 1ns / 1ps

module sorted_priority_queue_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_start_i,
  input  logic               cmd_busy_i,
  input  logic [1:0]         cmd_op_i,
  input  logic signed [31:0] cmd_value_i,
  input  logic               res_done_i,
  input  logic [1:0]         res_status_i,
  input  logic [4:0]         res_position_i,
  input  logic signed [31:0] res_head_value_i,
  input  logic               res_head_valid_i,
  input  logic [4:0]         res_entry_count_i,
  output int                 mismatch_count_o,
  output int                 pending_o
);

  // Shadow copy of the ascending store and its fill level.
  logic signed [31:0] shadow_entries [CAPACITY];
  int unsigned        shadow_count;

  // Result beats predicted but not yet seen, oldest first.
  spq_pkg::res_t expected_results [$];
  int            mismatches;

  // Applies one command to the shadow store and returns the result beat it causes.
  function automatic spq_pkg::res_t apply_queue_op(input logic [1:0] op,
                                                   input logic signed [31:0] val);
    spq_pkg::res_t res;
    int unsigned   idx;
    int unsigned   pos;
    logic [1:0]    status;
    status = spq_pkg::ST_MISSING;
    pos    = 0;
    case (op) inside
      spq_pkg::OP_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          status = spq_pkg::ST_FULL;
        end else begin
          // Equal values go behind the ones already stored.
          idx = 0;
          while (idx < shadow_count && shadow_entries[idx] <= val) idx++;
          for (int k = int'(shadow_count); k > int'(idx); k--) begin
            shadow_entries[k] = shadow_entries[k-1];
          end
          shadow_entries[idx] = val;
          shadow_count++;
          status = spq_pkg::ST_OK;
          pos    = idx;
        end
      end
      spq_pkg::OP_REMOVE, spq_pkg::OP_FIND: begin
        // The match nearest the head is the one that counts.
        idx = 0;
        while (idx < shadow_count && shadow_entries[idx] != val) idx++;
        if (idx < shadow_count) begin
          if (op == spq_pkg::OP_REMOVE) begin
            for (int unsigned k = idx; k + 1 < shadow_count; k++) begin
              shadow_entries[k] = shadow_entries[k+1];
            end
            shadow_count--;
          end
          status = spq_pkg::ST_OK;
          pos    = idx;
        end
      end
      default: begin
        // Unknown operation: nothing changes.
        status = spq_pkg::ST_MISSING;
      end
    endcase
    res.status      = status;
    res.position    = pos[spq_pkg::PosW-1:0];
    res.head_value  = (shadow_count > 0) ? shadow_entries[0] : '0;
    res.head_valid  = (shadow_count > 0);
    res.entry_count = shadow_count[spq_pkg::PosW-1:0];
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(input string field, input logic signed [32:0] expected,
                             input logic signed [32:0] actual);
    if (expected !== actual) begin
      $error("%s: expected %0d, actual %0d", field, expected, actual);
      mismatches++;
    end
  endtask

  // Result beats are checked before the command beat of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    spq_pkg::res_t exp_res;
    if (!rst_ni) begin
      shadow_count = 0;
      expected_results.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (res_done_i) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command waiting for it");
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("status", exp_res.status, res_status_i);
          check_field("position", exp_res.position, res_position_i);
          check_field("head_value", $signed(exp_res.head_value), res_head_value_i);
          check_field("head_valid", exp_res.head_valid, res_head_valid_i);
          check_field("entry_count", exp_res.entry_count, res_entry_count_i);
        end
      end
      if (cmd_start_i && !cmd_busy_i) begin
        expected_results.push_back(apply_queue_op(cmd_op_i, cmd_value_i));
      end
      mismatch_count_o <= mismatches;
      pending_o <= expected_results.size();
    end
  end

endmodule

### tb/sv/sorted_priority_queue_top_tb.sv
// Testbench top for the sorted priority queue: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;

  localparam int unsigned CAPACITY     = 16;
  localparam logic [1:0]  OP_NOP       = 2'd3;
  localparam int          RANDOM_ITEMS = 1200;
  localparam int          IDLE_LIMIT   = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [1:0]         op_i = spq_pkg::OP_INSERT;
  logic signed [31:0] item_value_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [1:0]         status_o;
  logic [4:0]         position_o;
  logic signed [31:0] head_value_o;
  logic               head_valid_o;
  logic [4:0]         entry_count_o;

  int mismatch_count;
  int pending_results;
  int idle_cycles = 0;

  // Values recently inserted, so that removes and finds often hit.
  logic [31:0] inserted_values [$];

  sorted_priority_queue_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .item_value_i (item_value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .position_o   (position_o),
    .head_value_o (head_value_o),
    .head_valid_o (head_valid_o),
    .entry_count_o(entry_count_o)
  );

  sorted_priority_queue_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_start_i      (start_i),
    .cmd_busy_i       (busy_o),
    .cmd_op_i         (op_i),
    .cmd_value_i      (item_value_i),
    .res_done_i       (done_o),
    .res_status_i     (status_o),
    .res_position_i   (position_o),
    .res_head_value_i (head_value_o),
    .res_head_valid_i (head_valid_o),
    .res_entry_count_i(entry_count_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: too many cycles without any beat on either channel ends the run.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a beat", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Drives one command beat after a gap and returns at the edge that takes it.
  task automatic send_cmd(input logic [1:0] op, input logic [31:0] val, input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    op_i         <= op;
    item_value_i <= val;
    if (op == spq_pkg::OP_INSERT) begin
      inserted_values.push_back(val);
      if (inserted_values.size() > 48) void'(inserted_values.pop_front());
    end
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
  endtask

  // Holds commands off until every predicted result beat has arrived.
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending_results != 0);
    @(posedge clk_i);
  endtask

  // Many small values for duplicates, some extremes, the rest anywhere.
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 32'($signed($urandom_range(0, 8)) - 4);
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  // A remove or find target: usually a value that went in earlier.
  function automatic logic [31:0] pick_target(input bit take_out);
    int unsigned idx;
    logic [31:0] val;
    if (inserted_values.size() > 0 && $urandom_range(0, 9) < 7) begin
      idx = $urandom_range(0, inserted_values.size() - 1);
      val = inserted_values[idx];
      if (take_out) inserted_values.delete(idx);
      return val;
    end
    return pick_value();
  endfunction

  initial begin
    bit          fill_phase;
    bit          back_to_back;
    int unsigned r;
    int          gap;
    logic [1:0]  op;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty store, extremes, duplicates, head and tail, full store.
    send_cmd(spq_pkg::OP_FIND,   32'd5,         0);
    send_cmd(spq_pkg::OP_REMOVE, 32'd5,         1);
    send_cmd(OP_NOP,             32'hFFFF_FFFF, 0);
    send_cmd(spq_pkg::OP_INSERT, 32'h7FFF_FFFF, 0);
    send_cmd(spq_pkg::OP_INSERT, 32'h8000_0000, 2);
    send_cmd(spq_pkg::OP_INSERT, 32'h0000_0000, 0);
    send_cmd(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 0);
    send_cmd(spq_pkg::OP_INSERT, 32'h0000_0000, 0);
    send_cmd(spq_pkg::OP_FIND,   32'h0000_0000, 0);
    send_cmd(spq_pkg::OP_REMOVE, 32'h0000_0000, 0);
    send_cmd(spq_pkg::OP_FIND,   32'h7FFF_FFFF, 3);
    send_cmd(spq_pkg::OP_REMOVE, 32'h8000_0000, 0);
    // Three entries remain; fill the store to capacity.
    for (int k = 0; k < CAPACITY - 3; k++) begin
      send_cmd(spq_pkg::OP_INSERT, (k % 4 == 0) ? 32'd1 : $urandom(), $urandom_range(0, 2));
    end
    send_cmd(spq_pkg::OP_INSERT, 32'd7,         0);
    send_cmd(OP_NOP,             32'd0,         0);
    send_cmd(spq_pkg::OP_FIND,   32'd1,         0);
    send_cmd(spq_pkg::OP_REMOVE, 32'h7FFF_FFFF, 0);
    wait_drained();

    // Random part: phases that lean toward filling or draining the store.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) back_to_back = ($urandom_range(0, 3) == 0);
      if (n % 100 == 0) fill_phase = ~fill_phase;
      if (n == RANDOM_ITEMS / 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op = OP_NOP;
      end else if (r < (fill_phase ? 68 : 30)) begin
        op = spq_pkg::OP_INSERT;
      end else if (r < (fill_phase ? 85 : 75)) begin
        op = spq_pkg::OP_REMOVE;
      end else begin
        op = spq_pkg::OP_FIND;
      end
      gap = back_to_back ? 0 : $urandom_range(0, 14);
      case (op)
        spq_pkg::OP_INSERT: send_cmd(op, pick_value(), gap);
        spq_pkg::OP_REMOVE: send_cmd(op, pick_target(1'b1), gap);
        spq_pkg::OP_FIND:   send_cmd(op, pick_target(1'b0), gap);
        default:            send_cmd(op, $urandom(), gap);
      endcase
    end

    // Let the last beats arrive, then allow for stray extra results.
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
